// File: hdl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and character constants for the string literal unescaper.
// ----------------------------------------------------------------------------
package isu_pkg;

  typedef enum logic [2:0] {
    ST_CHAR         = 3'd0,
    ST_END          = 3'd1,
    ST_BAD_ESCAPE   = 3'd2,
    ST_UNTERMINATED = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;

endpackage

// File: hdl/interpolated_string_unescaper_top.sv
// ----------------------------------------------------------------------------
// interpolated_string_unescaper_top
// Decodes the body of an interpolated string literal one byte per word.
// ----------------------------------------------------------------------------
// Takes one body byte per cycle when not stalled; the result is shown in the cycle
// after the byte is taken, through a result register that can be refilled while
// its word is taken. Most bytes give one word, a backslash gives none; an escape
// inside braces or a nested string gives two words (backslash, then the byte), and
// the input stalls while the second word sits in the hold register. A status other
// than char ends the literal and clears brace, nesting and escape state.
module interpolated_string_unescaper_top #(
  parameter int MAX_DEPTH = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_char
  input  logic              in_tuser,   // [0] end_of_input
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_char
  output isu_pkg::status_t  out_tuser,  // [2:0] status
  output logic              out_tlast
);
  import isu_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam logic [LW-1:0] MAX_LVL = LW'(MAX_DEPTH);

  logic [LW-1:0] brace_r, brace_nxt;
  logic [LW-1:0] nested_r, nested_nxt;
  logic          esc_r, esc_nxt;

  logic          out_valid_r;
  logic [7:0]    out_char_r;
  status_t       out_status_r;
  logic          out_last_r;
  logic          hold_valid_r;
  logic [7:0]    hold_char_r;

  logic [1:0]    res_cnt;
  logic [7:0]    w0_char;
  status_t       w0_status;
  logic          w0_last;
  logic          top;
  logic          in_fire, out_fire;

  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;
  assign in_tready = ~hold_valid_r & (~out_valid_r | out_tready);
  assign top       = (brace_r == '0) && (nested_r == '0);

  always_comb begin
    brace_nxt  = brace_r;
    nested_nxt = nested_r;
    esc_nxt    = esc_r;
    res_cnt    = 2'd1;
    w0_char    = in_tdata;
    w0_status  = ST_CHAR;
    w0_last    = 1'b1;
    if (in_tuser) begin
      w0_char   = '0;
      w0_status = ST_UNTERMINATED;
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (top) begin
        case (in_tdata)
          CH_BACKSLASH: w0_char = CH_BACKSLASH;
          CH_N:         w0_char = CH_LF;
          CH_R:         w0_char = CH_CR;
          CH_T:         w0_char = CH_TAB;
          CH_QUOTE:     w0_char = CH_QUOTE;
          default: begin
            w0_char   = '0;
            w0_status = ST_BAD_ESCAPE;
          end
        endcase
      end else begin
        res_cnt = 2'd2;
        w0_char = CH_BACKSLASH;
        w0_last = 1'b0;
      end
    end else if (in_tdata == CH_BACKSLASH) begin
      esc_nxt = 1'b1;
      res_cnt = 2'd0;
    end else if (in_tdata == CH_QUOTE && top) begin
      w0_char   = '0;
      w0_status = ST_END;
    end else if (in_tdata == CH_QUOTE && brace_r != '0) begin
      if (nested_r != '0) begin
        nested_nxt = nested_r - 1'b1;
      end else if (nested_r >= MAX_LVL) begin
        w0_char   = '0;
        w0_status = ST_OVERFLOW;
      end else begin
        nested_nxt = nested_r + 1'b1;
      end
    end else if (in_tdata == CH_LBRACE && nested_r == '0) begin
      if (brace_r >= MAX_LVL) begin
        w0_char   = '0;
        w0_status = ST_OVERFLOW;
      end else begin
        brace_nxt = brace_r + 1'b1;
      end
    end else if (in_tdata == CH_RBRACE && nested_r == '0) begin
      if (brace_r != '0) begin
        brace_nxt = brace_r - 1'b1;
      end
    end
    if (w0_status != ST_CHAR) begin
      brace_nxt  = '0;
      nested_nxt = '0;
      esc_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brace_r      <= '0;
      nested_r     <= '0;
      esc_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        brace_r  <= brace_nxt;
        nested_r <= nested_nxt;
        esc_r    <= esc_nxt;
      end
      if (in_fire && res_cnt != 2'd0) begin
        out_valid_r  <= 1'b1;
        out_char_r   <= w0_char;
        out_status_r <= w0_status;
        out_last_r   <= w0_last;
        hold_valid_r <= (res_cnt == 2'd2);
        hold_char_r  <= in_tdata;
      end else if (out_fire) begin
        if (hold_valid_r) begin
          out_char_r   <= hold_char_r;
          out_status_r <= ST_CHAR;
          out_last_r   <= 1'b1;
          hold_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("hold word without result word");

  a_first_has_follower: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> hold_valid_r)
    else $error("non-final word with no second word queued");

  a_status_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_CHAR) |-> (out_char_r == '0 && out_last_r))
    else $error("terminal status with nonzero char or not last");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser) |=> (brace_r == '0 && nested_r == '0 && !esc_r))
    else $error("state not cleared after end of input");

  a_nested_in_brace: assert property (@(posedge clk) disable iff (!rst_n)
    (nested_r != '0) |-> (brace_r != '0))
    else $error("nested string open outside braces");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interpolated string literal unescaper.
// ----------------------------------------------------------------------------
// A directed list covers every top-level escape, a bad escape, end of input
// with a pending backslash, pass-through escapes, nested strings and braces.
// Random literals follow: well-formed bodies with interpolations, deep brace
// runs that may overflow, broken literals and raw noise. Each accepted byte
// is decoded by a local model; every output word is checked against it.
// Both sides stall at random; one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import isu_pkg::*;

  localparam int DEPTH_MAX  = 15;
  localparam int RAND_ITEMS = 900;
  localparam int STALL_MAX  = 2000;
  localparam int HOLD_LEN   = 80;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    status_t    st;
    logic       last;
  } dec_word_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_tvalid = 1'b0;
  logic      in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic      in_tuser = 1'b0;
  logic      out_tvalid;
  logic      out_tready = 1'b0;
  logic [7:0] out_tdata;
  status_t   out_tuser;
  logic      out_tlast;

  src_byte_t src_q[$];
  dec_word_t dec_q[$];

  int  brace_lvl = 0;
  int  nest_lvl = 0;
  bit  esc_open = 1'b0;

  int  errors = 0;
  int  rnd_count = 0;
  bit  no_idle = 1'b0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_cnt = 0;
  int  stall_cycles = 0;

  interpolated_string_unescaper_top #(.MAX_DEPTH(DEPTH_MAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_char
    .in_tuser   (in_tuser),   // [0] end_of_input
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_char
    .out_tuser  (out_tuser),  // [2:0] status
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---- decode model ----
  task automatic push_word(input logic [7:0] c, input status_t s, input logic l);
    dec_word_t w;
    w.ch   = c;
    w.st   = s;
    w.last = l;
    dec_q.push_back(w);
  endtask

  task automatic end_literal(input status_t s);
    brace_lvl = 0;
    nest_lvl  = 0;
    esc_open  = 1'b0;
    push_word(8'h00, s, 1'b1);
  endtask

  task automatic decode_byte(input src_byte_t b);
    bit         top;
    bit         bad;
    bit         ovf;
    logic [7:0] v;
    top = (brace_lvl == 0) && (nest_lvl == 0);
    bad = 1'b0;
    ovf = 1'b0;
    v   = 8'h00;
    if (b.eoi) begin
      end_literal(ST_UNTERMINATED);
    end else if (esc_open) begin
      esc_open = 1'b0;
      if (top) begin
        case (b.ch)
          CH_BACKSLASH: v = CH_BACKSLASH;
          CH_N:         v = CH_LF;
          CH_R:         v = CH_CR;
          CH_T:         v = CH_TAB;
          CH_QUOTE:     v = CH_QUOTE;
          default:      bad = 1'b1;
        endcase
        if (bad) end_literal(ST_BAD_ESCAPE);
        else push_word(v, ST_CHAR, 1'b1);
      end else begin
        push_word(CH_BACKSLASH, ST_CHAR, 1'b0);
        push_word(b.ch, ST_CHAR, 1'b1);
      end
    end else if (b.ch == CH_BACKSLASH) begin
      esc_open = 1'b1;
    end else if (b.ch == CH_QUOTE && top) begin
      end_literal(ST_END);
    end else begin
      if (b.ch == CH_QUOTE && brace_lvl > 0) begin
        if (nest_lvl > 0) nest_lvl--;
        else if (nest_lvl >= DEPTH_MAX) ovf = 1'b1;
        else nest_lvl++;
      end else if (b.ch == CH_LBRACE && nest_lvl == 0) begin
        if (brace_lvl >= DEPTH_MAX) ovf = 1'b1;
        else brace_lvl++;
      end else if (b.ch == CH_RBRACE && nest_lvl == 0) begin
        if (brace_lvl > 0) brace_lvl--;
      end
      if (ovf) end_literal(ST_OVERFLOW);
      else push_word(b.ch, ST_CHAR, 1'b1);
    end
  endtask

  // ---- stimulus generation ----
  task automatic push_byte(input logic [7:0] c, input logic e);
    src_byte_t b;
    b.ch  = c;
    b.eoi = e;
    src_q.push_back(b);
    rnd_count++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_BACKSLASH || c == CH_QUOTE || c == CH_LBRACE || c == CH_RBRACE);
    return c;
  endfunction

  task automatic push_top_escape();
    push_byte(CH_BACKSLASH, 1'b0);
    case ($urandom_range(4))
      0: push_byte(CH_N, 1'b0);
      1: push_byte(CH_R, 1'b0);
      2: push_byte(CH_T, 1'b0);
      3: push_byte(CH_BACKSLASH, 1'b0);
      default: push_byte(CH_QUOTE, 1'b0);
    endcase
  endtask

  task automatic gen_nested_string();
    int n;
    n = $urandom_range(4);
    if ($urandom_range(1)) push_byte(CH_DOLLAR, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    repeat (n) begin
      case ($urandom_range(4))
        0: push_byte(CH_LBRACE, 1'b0);
        1: push_byte(CH_RBRACE, 1'b0);
        2: begin
          push_byte(CH_BACKSLASH, 1'b0);
          push_byte(8'($urandom_range(255)), 1'b0);
        end
        default: push_byte(plain_byte(), 1'b0);
      endcase
    end
    push_byte(CH_QUOTE, 1'b0);
  endtask

  task automatic gen_interp();
    int m;
    m = $urandom_range(1, 5);
    push_byte(CH_LBRACE, 1'b0);
    repeat (m) begin
      case ($urandom_range(9))
        0, 1, 2, 3: push_byte(plain_byte(), 1'b0);
        4, 5: begin
          push_byte(CH_BACKSLASH, 1'b0);
          push_byte(8'($urandom_range(255)), 1'b0);
        end
        6, 7: gen_nested_string();
        8: begin
          push_byte(CH_LBRACE, 1'b0);
          push_byte(plain_byte(), 1'b0);
          if ($urandom_range(1)) gen_nested_string();
          push_byte(CH_RBRACE, 1'b0);
        end
        default: push_byte(CH_DOLLAR, 1'b0);
      endcase
    end
    push_byte(CH_RBRACE, 1'b0);
  endtask

  task automatic gen_literal(input bit broken);
    int n;
    n = $urandom_range(8);
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: push_byte(plain_byte(), 1'b0);
        5, 6: push_top_escape();
        default: gen_interp();
      endcase
    end
    if (broken) begin
      case ($urandom_range(2))
        0: begin
          push_byte(CH_BACKSLASH, 1'b0);
          push_byte(8'($urandom_range(255)), 1'b0);
        end
        1: push_byte(8'($urandom_range(255)), 1'b1);
        default: begin
          push_byte(CH_BACKSLASH, 1'b0);
          push_byte(8'($urandom_range(255)), 1'b1);
        end
      endcase
    end else if ($urandom_range(11) == 0) begin
      push_byte(8'($urandom_range(255)), 1'b1);
    end else begin
      push_byte(CH_QUOTE, 1'b0);
    end
  endtask

  // brace runs from 3 up to two past the depth limit; deep enough ones overflow
  task automatic gen_deep();
    int k;
    k = $urandom_range(3, DEPTH_MAX + 2);
    repeat (k) push_byte(CH_LBRACE, 1'b0);
    push_byte(plain_byte(), 1'b0);
    if ($urandom_range(1)) gen_nested_string();
    repeat (k) push_byte(CH_RBRACE, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) push_byte(8'($urandom_range(255)), ($urandom_range(15) == 0));
  endtask

  task automatic gen_random(input int target);
    int r;
    while (rnd_count < target) begin
      r = $urandom_range(99);
      if (r < 65) gen_literal(1'b0);
      else if (r < 75) gen_deep();
      else if (r < 88) gen_literal(1'b1);
      else gen_noise();
    end
  endtask

  task automatic wait_drained();
    while (src_q.size() != 0 || dec_q.size() != 0) @(negedge clk);
  endtask

  // ---- directed, then random phases ----
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_byte("a", 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte(CH_N, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte(CH_R, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte(CH_T, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte(CH_BACKSLASH, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_RBRACE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte("x", 1'b0);
    push_byte(CH_LBRACE, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte("q", 1'b0);
    push_byte(CH_DOLLAR, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_LBRACE, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_RBRACE, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_BACKSLASH, 1'b0); push_byte(8'hFF, 1'b1);
    wait_drained();

    rnd_count = 0;
    no_idle = 1'b1;
    gen_random(RAND_ITEMS / 4);
    wait_drained();
    no_idle = 1'b0;

    gen_random(RAND_ITEMS * 2 / 3);
    hold_req++;
    wait_drained();

    gen_random(RAND_ITEMS);
    wait_drained();

    repeat (20) @(negedge clk);
    if (errors == 0 && dec_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---- input driver ----
  always @(posedge clk) begin
    src_byte_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tuser  <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid && in_tready) begin
        cur = src_q.pop_front();
        decode_byte(cur);
      end
      if (src_q.size() != 0 && (no_idle || $urandom_range(99) >= 28)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= src_q[0].ch;
        in_tuser  <= src_q[0].eoi;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---- output monitor ----
  always @(posedge clk) begin
    dec_word_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (dec_q.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("unexpected word: char %02h st %0d last %0d",
                     out_tdata, out_tuser, out_tlast);
        end else begin
          w = dec_q.pop_front();
          if (out_tdata !== w.ch || out_tuser !== w.st || out_tlast !== w.last) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("mismatch: exp char %02h st %0d last %0d, got char %02h st %0d last %0d",
                       w.ch, w.st, w.last, out_tdata, out_tuser, out_tlast);
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= 28);
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("timeout: no word moved in %0d cycles", STALL_MAX);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
